### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dtq_pkg.sv
// Types and constants of the deadline timer queue.
package dtq_pkg;

  localparam int TW = 32;   // millisecond time width
  localparam int DW = 24;   // stored delay width

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_START   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_CANCEL  = 2'd3;

  // saturating count of due slots seen in one pass
  typedef logic [1:0] cnt_t;
  localparam cnt_t CNT_NONE = 2'd0;
  localparam cnt_t CNT_ONE  = 2'd1;
  localparam cnt_t CNT_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RST  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  // one deadline entry entering the picker
  typedef struct packed {
    logic          clr;
    logic          vld;
    logic          last;
    logic [TW-1:0] diff;
  } cand_t;

  // picker status at the end of a pass
  typedef struct packed {
    logic done;
    cnt_t cnt;
  } pick_t;

endpackage

### rtl/core/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dtq_pick.sv
// Running minimum over one pass: earliest due deadline, lowest slot on ties.
module dtq_pick #(
  parameter int IW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dtq_pkg::cand_t cand,
  input  logic [IW-1:0]  cand_idx,
  output dtq_pkg::pick_t res,
  output logic [IW-1:0]  best_idx
);

  dtq_pkg::cnt_t            cnt_r, cnt_nxt;
  logic                     done_r;
  logic [dtq_pkg::TW-1:0]   best_key_r;
  logic [IW-1:0]            best_idx_r;
  logic [dtq_pkg::TW-1:0]   key;
  logic                     due;
  logic                     take;

  // due when deadline - now is zero or negative
  assign due  = cand.vld && ((cand.diff == '0) || cand.diff[dtq_pkg::TW-1]);
  assign key  = cand.diff ^ {1'b1, {(dtq_pkg::TW-1){1'b0}}};
  // strict compare keeps the lower slot on equal keys (ascending scan)
  assign take = due && ((cnt_r == dtq_pkg::CNT_NONE) || (key < best_key_r));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cand.clr) begin
      cnt_nxt = dtq_pkg::CNT_NONE;
    end else if (due) begin
      cnt_nxt = (cnt_r == dtq_pkg::CNT_NONE) ? dtq_pkg::CNT_ONE : dtq_pkg::CNT_MANY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= dtq_pkg::CNT_NONE;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= cand.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r <= key;
      best_idx_r <= cand_idx;
    end
  end

  assign res.done = done_r;
  assign res.cnt  = cnt_r;
  assign best_idx = best_idx_r;

endmodule

### rtl/core/deadline_timer_queue.sv
// Top level of the deadline-ordered one-shot timer queue.
//
// Use: a command beat is taken when start is high and busy is low. in_mode picks
// tick, start (arm at now + in_delay_ms, delay kept), restart (arm at now + kept
// delay) or cancel; in_slot names the slot. Slots at or above SLOTS are ignored.
// Start and cancel leave busy low, so they may follow each other every cycle.
// Restart reads the kept-delay RAM, then holds busy in ST_RST while it writes the deadline.
// A tick advances the millisecond clock and sweeps the deadline RAM, one slot per
// cycle. Each sweep yields the earliest due slot; a tick with k expiries takes
// max(k,1) sweeps, so the deadline RAM read port sets the rate.
// Results: out_valid strobes for one cycle per expiry, earliest deadline first,
// lower slot first on a tie; out_is_last marks the final expiry of the tick. The
// receiver cannot stall, so each result beat is shown once and not held.
// Reset (synchronous, rst_n low): clock to zero, every slot disarmed, kept delays
// read as zero until first written. No clearing sweep is needed.
`include "assert_macros.svh"

module deadline_timer_queue #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_slot,
  input  logic [23:0] in_delay_ms,
  output logic        out_valid,
  output logic [3:0]  out_expired_slot,
  output logic        out_is_last
);

  localparam int IW = $clog2(SLOTS);

  // control state
  dtq_pkg::state_t          st_r, st_nxt;
  logic [dtq_pkg::TW-1:0]   now_r, now_nxt;
  logic [SLOTS-1:0]         armed_r, armed_nxt;
  logic [SLOTS-1:0]         sv_vld_r, sv_vld_nxt;   // kept delay written since reset
  logic                     iss_on_r, iss_on_nxt;
  logic [IW-1:0]            iss_idx_r, iss_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // sweep pipeline: p1 = RAM read in flight, p2 = difference registered
  logic                     p1_on_r, p1_last_r;
  logic [IW-1:0]            p1_idx_r;
  logic                     p2_vld_r, p2_last_r;
  logic [IW-1:0]            p2_idx_r;
  logic [dtq_pkg::TW-1:0]   p2_diff_r;

  logic [IW-1:0]            op_idx_r;
  logic [3:0]               out_slot_r;
  logic                     out_last_r;

  logic                     acc, in_ok, pass_go;
  logic [IW-1:0]            in_idx;
  logic                     dl_we, sd_we, sd_re;
  logic [IW-1:0]            dl_waddr;
  logic [dtq_pkg::TW-1:0]   dl_wdata, dl_rdata;
  logic [dtq_pkg::DW-1:0]   sd_rdata, sd_val;

  dtq_pkg::cand_t           cand;
  dtq_pkg::pick_t           res;
  logic [IW-1:0]            best_idx;

  assign busy   = (st_r != dtq_pkg::ST_IDLE);
  assign acc    = start && !busy;
  assign in_ok  = int'(in_slot) < SLOTS;
  assign in_idx = IW'(in_slot);
  assign sd_val = sv_vld_r[op_idx_r] ? sd_rdata : '0;

  // deadlines: written by start and restart, read by the sweep
  dtq_ram #(.WIDTH(dtq_pkg::TW), .DEPTH(SLOTS)) u_dl_ram (
    .clk  (clk),
    .we   (dl_we),
    .waddr(dl_waddr),
    .wdata(dl_wdata),
    .re   (iss_on_r),
    .raddr(iss_idx_r),
    .rdata(dl_rdata)
  );

  // kept delays: written by start, read by restart
  dtq_ram #(.WIDTH(dtq_pkg::DW), .DEPTH(SLOTS)) u_sd_ram (
    .clk  (clk),
    .we   (sd_we),
    .waddr(in_idx),
    .wdata(in_delay_ms),
    .re   (sd_re),
    .raddr(in_idx),
    .rdata(sd_rdata)
  );

  assign cand.clr  = pass_go;
  assign cand.vld  = p2_vld_r;
  assign cand.last = p2_last_r;
  assign cand.diff = p2_diff_r;

  dtq_pick #(.IW(IW)) u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .cand    (cand),
    .cand_idx(p2_idx_r),
    .res     (res),
    .best_idx(best_idx)
  );

  always_comb begin
    st_nxt        = st_r;
    now_nxt       = now_r;
    armed_nxt     = armed_r;
    sv_vld_nxt    = sv_vld_r;
    iss_on_nxt    = iss_on_r;
    iss_idx_nxt   = iss_idx_r;
    out_valid_nxt = 1'b0;
    pass_go       = 1'b0;
    dl_we         = 1'b0;
    dl_waddr      = in_idx;
    dl_wdata      = now_r + dtq_pkg::TW'(in_delay_ms);
    sd_we         = 1'b0;
    sd_re         = 1'b0;
    case (st_r)
      dtq_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_mode)
            dtq_pkg::MODE_TICK: begin
              now_nxt = now_r + dtq_pkg::TW'(1);
              st_nxt  = dtq_pkg::ST_SCAN;
              pass_go = 1'b1;
            end
            dtq_pkg::MODE_START: begin
              if (in_ok) begin
                dl_we              = 1'b1;
                sd_we              = 1'b1;
                sv_vld_nxt[in_idx] = 1'b1;
                armed_nxt[in_idx]  = 1'b1;
              end
            end
            dtq_pkg::MODE_RESTART: begin
              if (in_ok) begin
                sd_re  = 1'b1;
                st_nxt = dtq_pkg::ST_RST;
              end
            end
            dtq_pkg::MODE_CANCEL: begin
              if (in_ok) begin
                armed_nxt[in_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      dtq_pkg::ST_RST: begin
        dl_we               = 1'b1;
        dl_waddr            = op_idx_r;
        dl_wdata            = now_r + dtq_pkg::TW'(sd_val);
        armed_nxt[op_idx_r] = 1'b1;
        st_nxt              = dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_SCAN: begin
        if (iss_on_r) begin
          if (iss_idx_r == IW'(SLOTS - 1)) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_idx_nxt = iss_idx_r + IW'(1);
          end
        end
        // end of a pass: report the winner if any, sweep again if more are due
        if (res.done) begin
          if (res.cnt == dtq_pkg::CNT_NONE) begin
            st_nxt = dtq_pkg::ST_IDLE;
          end else begin
            out_valid_nxt       = 1'b1;
            armed_nxt[best_idx] = 1'b0;
            if (res.cnt == dtq_pkg::CNT_ONE) begin
              st_nxt = dtq_pkg::ST_IDLE;
            end else begin
              pass_go = 1'b1;
            end
          end
        end
      end
      default: st_nxt = dtq_pkg::ST_IDLE;
    endcase
    if (pass_go) begin
      iss_on_nxt  = 1'b1;
      iss_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dtq_pkg::ST_IDLE;
      now_r       <= '0;
      armed_r     <= '0;
      sv_vld_r    <= '0;
      iss_on_r    <= 1'b0;
      iss_idx_r   <= '0;
      out_valid_r <= 1'b0;
      p1_on_r     <= 1'b0;
      p1_last_r   <= 1'b0;
      p2_vld_r    <= 1'b0;
      p2_last_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      now_r       <= now_nxt;
      armed_r     <= armed_nxt;
      sv_vld_r    <= sv_vld_nxt;
      iss_on_r    <= iss_on_nxt;
      iss_idx_r   <= iss_idx_nxt;
      out_valid_r <= out_valid_nxt;
      p1_on_r     <= iss_on_r;
      p1_last_r   <= iss_on_r && (iss_idx_r == IW'(SLOTS - 1));
      p2_vld_r    <= p1_on_r && armed_r[p1_idx_r];
      p2_last_r   <= p1_last_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    p1_idx_r  <= iss_idx_r;
    p2_idx_r  <= p1_idx_r;
    p2_diff_r <= dl_rdata - now_r;
    if (acc) begin
      op_idx_r <= in_idx;
    end
    if (out_valid_nxt) begin
      out_slot_r <= 4'(best_idx);
      out_last_r <= (res.cnt == dtq_pkg::CNT_ONE);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_slot_r;
  assign out_is_last      = out_last_r;

  // results only come out of a sweep
  `DTQ_ASSERT_IMP(a_out_from_scan, out_valid, $past(st_r == dtq_pkg::ST_SCAN), "beat outside sweep")
  // no deadline reads issued while idle
  `DTQ_ASSERT_IMP(a_idle_no_issue, !busy, !iss_on_r, "sweep read while idle")
  // a non-final expiry is followed by another sweep
  `DTQ_ASSERT_IMP(a_more_keeps_scan, out_valid && !out_is_last, st_r == dtq_pkg::ST_SCAN, "sweep ended early")
  // an accepted tick always starts a sweep
  `DTQ_ASSERT_NXT(a_tick_busy, acc && (in_mode == dtq_pkg::MODE_TICK), busy, "tick not swept")

endmodule

### bench/dtq_expiry_checker.sv
// Expiry checker for the deadline timer queue: mirrors the slot bank and checks each result beat.
module dtq_expiry_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_slot,
  input  logic [23:0] in_delay_ms,
  input  logic        out_valid,
  input  logic [3:0]  out_expired_slot,
  input  logic        out_is_last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [3:0] slot;
    logic       last;
  } expiry_t;

  logic [dtq_pkg::TW-1:0] now_ms;
  logic [dtq_pkg::TW-1:0] deadline [SLOTS];
  logic [dtq_pkg::DW-1:0] kept_delay [SLOTS];
  logic [SLOTS-1:0]       armed;
  expiry_t                due_expiries [$];
  int                     fail_count = 0;

  // Reached when (deadline - now) as two's complement is zero or negative.
  function automatic logic is_due(logic [dtq_pkg::TW-1:0] dl);
    logic [dtq_pkg::TW-1:0] diff;
    diff = dl - now_ms;
    return (diff == '0) || diff[dtq_pkg::TW-1];
  endfunction

  // Advance the clock one ms and queue the slots that fire, earliest first.
  task automatic fire_due_slots();
    logic [3:0]             order [SLOTS];
    logic [dtq_pkg::TW-1:0] best_key;
    logic [dtq_pkg::TW-1:0] key;
    expiry_t                beat;
    int                     best;
    int                     n;
    n = 0;
    now_ms = now_ms + dtq_pkg::TW'(1);
    do begin
      best = -1;
      best_key = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (armed[i] && is_due(deadline[i])) begin
          // signed distance biased so an unsigned compare orders it; strict < keeps lower slot on a tie
          key = (deadline[i] - now_ms) ^ {1'b1, {(dtq_pkg::TW-1){1'b0}}};
          if (best < 0 || key < best_key) begin
            best = i;
            best_key = key;
          end
        end
      end
      if (best >= 0) begin
        armed[best] = 1'b0;
        order[n] = 4'(best);
        n++;
      end
    end while (best >= 0);
    for (int j = 0; j < n; j++) begin
      beat.slot = order[j];
      beat.last = (j == n - 1);
      due_expiries.insert(due_expiries.size(), beat);
    end
  endtask

  always @(posedge clk) begin : watch
    expiry_t want;
    if (!rst_n) begin
      now_ms = '0;
      armed = '0;
      for (int i = 0; i < SLOTS; i++) begin
        kept_delay[i] = '0;
        deadline[i] = '0;
      end
      due_expiries.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (out_valid !== 1'b1) begin
          fail_count++;
          $display("%0t: out_valid expected 0 or 1, got %b", $time, out_valid);
        end else if (due_expiries.size() == 0) begin
          fail_count++;
          $display("%0t: result beat expected none, got slot %0d last %b",
                   $time, out_expired_slot, out_is_last);
        end else begin
          want = due_expiries.pop_front();
          if (out_expired_slot !== want.slot) begin
            fail_count++;
            $display("%0t: expired_slot expected %0d, got %0d",
                     $time, want.slot, out_expired_slot);
          end
          if (out_is_last !== want.last) begin
            fail_count++;
            $display("%0t: is_last expected %b, got %b", $time, want.last, out_is_last);
          end
        end
      end
      if (start && !busy) begin
        case (in_mode)
          dtq_pkg::MODE_TICK: fire_due_slots();
          dtq_pkg::MODE_START:
            if (in_slot < SLOTS) begin
              kept_delay[in_slot] = in_delay_ms;
              deadline[in_slot] = now_ms + dtq_pkg::TW'(in_delay_ms);
              armed[in_slot] = 1'b1;
            end
          dtq_pkg::MODE_RESTART:
            if (in_slot < SLOTS) begin
              deadline[in_slot] = now_ms + dtq_pkg::TW'(kept_delay[in_slot]);
              armed[in_slot] = 1'b1;
            end
          dtq_pkg::MODE_CANCEL:
            if (in_slot < SLOTS) armed[in_slot] = 1'b0;
          default: ;
        endcase
      end
    end
    errors <= fail_count;
    pending <= due_expiries.size();
  end

endmodule

### bench/deadline_timer_queue_tb.sv
// Testbench top of the deadline timer queue: drives command beats and gives the verdict.
module deadline_timer_queue_tb;

  localparam int SLOTS      = 16;
  localparam int SWEEP      = SLOTS + 3;       // length of one pass over the deadline RAM
  localparam int DIRECTED   = 25;
  localparam int TOTAL      = DIRECTED + 205;
  localparam int QUIET_FROM = TOTAL - 40;      // no idling in the closing stretch
  localparam int DRAIN      = 4 * SWEEP;       // covers a tick still sweeping with no expiry
  // worst case: TOTAL beats, each with up to 16 sweeps plus idle; keep plenty of margin
  localparam int LIMIT      = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [3:0]  in_slot;
  logic [23:0] in_delay_ms;
  logic        out_valid;
  logic [3:0]  out_expired_slot;
  logic        out_is_last;

  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;
  int calm = 0;            // beats left in a stretch without idling
  bit drained_mid = 1'b0;  // the mid-run pause has been taken

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deadline_timer_queue #(.SLOTS(SLOTS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_delay_ms      (in_delay_ms),
    .out_valid        (out_valid),
    .out_expired_slot (out_expired_slot),
    .out_is_last      (out_is_last)
  );

  dtq_expiry_checker #(.SLOTS(SLOTS)) expiry_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_delay_ms      (in_delay_ms),
    .out_valid        (out_valid),
    .out_expired_slot (out_expired_slot),
    .out_is_last      (out_is_last),
    .errors           (errors),
    .pending          (pending)
  );

  // Watchdog: a hung handshake or a lost expiry ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it (start high, busy low).
  // Returns in the time step of the accepting edge; start stays high unless the caller drops it.
  task automatic issue(input logic [1:0] mode, input logic [3:0] slot, input logic [23:0] delay);
    in_mode <= mode;
    in_slot <= slot;
    in_delay_ms <= delay;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  // Drop start and hold off until every predicted expiry has been reported.
  // The checker's count is registered, so it lags the last beat by that register.
  task automatic wait_all_fired();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Between beats: one mid-run pause, else random idle bursts and calm spells until QUIET_FROM.
  task automatic after_beat();
    if (!drained_mid && sent >= TOTAL / 2) begin
      drained_mid = 1'b1;
      wait_all_fired();
    end else if (sent < QUIET_FROM) begin
      if (calm > 0)
        calm--;
      else if ($urandom_range(0, 15) == 0)
        calm = $urandom_range(6, 20);
      else if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  // Mostly short delays so slots actually fire; now and then the full 24-bit range.
  function automatic logic [23:0] pick_delay();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 24'($urandom_range(0, 4));
    if (r < 16) return 24'($urandom_range(5, 40));
    return 24'($urandom);
  endfunction

  // Arm every slot in shuffled order with near-equal deadlines, then tick them out.
  // A spread of zero puts all sixteen expiries on one tick, ties resolved by slot.
  task automatic flood();
    logic [3:0] order [SLOTS];
    logic [3:0] tmp;
    int         j;
    int         spread;
    spread = $urandom_range(0, 2);
    for (int i = 0; i < SLOTS; i++) order[i] = 4'(i);
    for (int i = SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < SLOTS; i++) begin
      issue(dtq_pkg::MODE_START, order[i], 24'($urandom_range(0, spread)));
      after_beat();
    end
    repeat (3) begin
      issue(dtq_pkg::MODE_TICK, 4'($urandom), 24'($urandom));
      after_beat();
    end
  endtask

  initial begin : stimulus
    int         r;
    logic [1:0] m;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= dtq_pkg::MODE_TICK;
    in_slot <= '0;
    in_delay_ms <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick on an empty bank, with the ignored fields at their top values.
    issue(dtq_pkg::MODE_TICK, 4'hF, 24'hFFFFFF);
    // Restart of a never-started slot uses the zero kept delay: fires on the next tick.
    issue(dtq_pkg::MODE_RESTART, 4'd5, 24'h000000);
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'h000000);
    // Far deadline, zero delays, cancel of an armed and of an idle slot, re-start.
    issue(dtq_pkg::MODE_START, 4'd0, 24'hFFFFFF);
    issue(dtq_pkg::MODE_START, 4'd15, 24'd0);
    issue(dtq_pkg::MODE_START, 4'd9, 24'd0);
    issue(dtq_pkg::MODE_START, 4'd3, 24'd1);
    issue(dtq_pkg::MODE_CANCEL, 4'd3, 24'd0);
    issue(dtq_pkg::MODE_CANCEL, 4'd7, 24'd0);
    issue(dtq_pkg::MODE_START, 4'd9, 24'd2);      // replaces the zero-delay deadline
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'd0);        // slot 15 alone
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'd0);        // slot 9 at its new deadline
    // Restart with a kept delay, then again while armed.
    issue(dtq_pkg::MODE_RESTART, 4'd9, 24'd0);
    issue(dtq_pkg::MODE_RESTART, 4'd9, 24'd0);
    // One slot already overdue plus three tied slots: order by deadline, then slot.
    issue(dtq_pkg::MODE_START, 4'd4, 24'd0);
    issue(dtq_pkg::MODE_START, 4'd12, 24'd1);
    issue(dtq_pkg::MODE_START, 4'd2, 24'd1);
    issue(dtq_pkg::MODE_START, 4'd6, 24'd1);
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'd0);        // 4, 2, 6, 12
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'd0);        // 9
    issue(dtq_pkg::MODE_RESTART, 4'd15, 24'd0);
    issue(dtq_pkg::MODE_START, 4'd10, 24'hAAAAAA);
    issue(dtq_pkg::MODE_TICK, 4'd0, 24'h555555);   // 15
    issue(dtq_pkg::MODE_CANCEL, 4'd0, 24'd0);
    issue(dtq_pkg::MODE_CANCEL, 4'd10, 24'd0);
    wait_all_fired();

    // Random: single commands of every kind, with the odd flood of the whole bank.
    while (sent < TOTAL) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        flood();
      else begin
        m = (r < 40) ? dtq_pkg::MODE_TICK :
            (r < 72) ? dtq_pkg::MODE_START :
            (r < 86) ? dtq_pkg::MODE_RESTART : dtq_pkg::MODE_CANCEL;
        issue(m, 4'($urandom), pick_delay());
        after_beat();
      end
    end

    wait_all_fired();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dtq_pkg.sv
rtl/core/dtq_ram.sv
rtl/core/dtq_pick.sv
rtl/core/deadline_timer_queue.sv
bench/dtq_expiry_checker.sv
bench/deadline_timer_queue_tb.sv
